>>> sv/assert_macros.svh
// Assertion macros shared by the sequencer and datapath modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/wcpg_pkg.sv
// Package: types, constants and control word format of the pair generator
`timescale 1ns / 1ps

package wcpg_pkg;

    localparam int DEF_MAX_WINDOW = 4;

    localparam int TOKEN_BITS    = 20;
    localparam int VOCAB_BITS    = 21;
    localparam int WSIZE_BITS    = 3;
    localparam int IDX_BITS      = 23;
    localparam int KIND_BITS     = 3;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 21;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_VOCAB_SIZE  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ONE_STEP    = 2'd2;

    localparam logic [WSIZE_BITS-1:0] RST_WINDOW_SIZE = 3'd2;
    localparam logic [VOCAB_BITS-1:0] RST_VOCAB_SIZE  = 21'h100000;
    localparam logic                  RST_ONE_STEP    = 1'b1;

    // Microprogram addresses
    localparam int STEP_BITS = 4;
    localparam logic [STEP_BITS-1:0] S_WAIT   = 4'd0;
    localparam logic [STEP_BITS-1:0] S_CHECK  = 4'd1;
    localparam logic [STEP_BITS-1:0] S_WORD   = 4'd2;
    localparam logic [STEP_BITS-1:0] S_ITEST  = 4'd3;
    localparam logic [STEP_BITS-1:0] S_IVALID = 4'd4;
    localparam logic [STEP_BITS-1:0] S_MODE   = 4'd5;
    localparam logic [STEP_BITS-1:0] S_PAIR   = 4'd6;
    localparam logic [STEP_BITS-1:0] S_CTX    = 4'd7;
    localparam logic [STEP_BITS-1:0] S_SKIP   = 4'd8;
    localparam logic [STEP_BITS-1:0] S_FLUSH  = 4'd9;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LOAD,
        OP_EMIT_WC,
        OP_START_J,
        OP_PAIR,
        OP_EMIT_CTX,
        OP_NEXT_I,
        OP_FLUSH
    } op_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NEVER,
        C_NO_INPUT,
        C_CENTRE_INVALID,
        C_I_DONE,
        C_I_INVALID,
        C_ONE_STEP,
        C_J_MORE
    } cond_t;

    typedef enum logic [KIND_BITS-1:0] {
        PK_WORD        = 3'd0,
        PK_WORD_CTX    = 3'd1,
        PK_LEFT_LEFT   = 3'd2,
        PK_LEFT_RIGHT  = 3'd3,
        PK_RIGHT_RIGHT = 3'd4
    } pair_kind_t;

    typedef struct packed {
        logic                  kind;
        logic [TOKEN_BITS-1:0] token;
    } in_item_t;

    typedef struct packed {
        logic [KIND_BITS-1:0] pair_kind;
        logic [IDX_BITS-1:0]  row;
        logic [IDX_BITS-1:0]  col;
        logic                 last;
    } out_item_t;

    typedef struct packed {
        op_t                  op;
        cond_t                cond;
        logic [STEP_BITS-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic no_input;
        logic centre_invalid;
        logic i_done;
        logic i_invalid;
        logic one_step;
        logic j_more;
        logic stall;
    } dp_status_t;

endpackage

>>> sv/window_cooccurrence_pair_generator_top.sv
// Sliding-window co-occurrence pair generator: sequencer plus datapath.
// Input channel (in_valid/in_ready/in_data): one transfer per token or pad position.
// Output channel (out_valid/out_ready/out_data): one increment per transfer; the
// final increment caused by an input item carries last. Items whose center is
// empty produce nothing.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 window size,
// 1 vocab size, 2 one-step mode) in the same cycle; write only while idle.
// Sequencing: the microprogram steps one control word per cycle unless a stall holds it.
// An item whose center is empty goes from wait through the load step back to wait.
// Otherwise the word count is emitted and each of the 2W offset slots is tested:
// an empty slot is skipped, a full one runs the pair loop in two-step mode, then
// emits its context increment. W=4 two-step, full window: 45 increments.
// Each increment is held in the pending register until the next is known.
// A stalled receiver holds the output register and, once the one pending result
// is also full, freezes the sequencer; nothing is dropped. A new input item is
// taken while the last result of the previous one still waits in the output
// register.
// Reset empties the window and loads window size 2, vocab size 2^20, one-step on.
`timescale 1ns / 1ps

module window_cooccurrence_pair_generator_top
    import wcpg_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  in_item_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output out_item_t                out_data,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    ctrl_word_t ctrl;
    dp_status_t status;

    wcpg_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    wcpg_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .status    (status)
    );

endmodule

>>> sv/wcpg_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wcpg_seq
    import wcpg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t status,
    output ctrl_word_t ctrl
);

    logic [STEP_BITS-1:0] step_reg;
    logic [STEP_BITS-1:0] step_next;
    logic                 cond_hit;

    // Control store
    always_comb
    begin
        case (step_reg)
            S_WAIT:   ctrl = '{op: OP_ACCEPT,   cond: C_NO_INPUT,       target: S_WAIT};
            S_CHECK:  ctrl = '{op: OP_LOAD,     cond: C_CENTRE_INVALID, target: S_WAIT};
            S_WORD:   ctrl = '{op: OP_EMIT_WC,  cond: C_NEVER,          target: S_WAIT};
            S_ITEST:  ctrl = '{op: OP_NONE,     cond: C_I_DONE,         target: S_FLUSH};
            S_IVALID: ctrl = '{op: OP_NONE,     cond: C_I_INVALID,      target: S_SKIP};
            S_MODE:   ctrl = '{op: OP_START_J,  cond: C_ONE_STEP,       target: S_CTX};
            S_PAIR:   ctrl = '{op: OP_PAIR,     cond: C_J_MORE,         target: S_PAIR};
            S_CTX:    ctrl = '{op: OP_EMIT_CTX, cond: C_ALWAYS,         target: S_ITEST};
            S_SKIP:   ctrl = '{op: OP_NEXT_I,   cond: C_ALWAYS,         target: S_ITEST};
            S_FLUSH:  ctrl = '{op: OP_FLUSH,    cond: C_ALWAYS,         target: S_WAIT};
            default:  ctrl = '{op: OP_NONE,     cond: C_ALWAYS,         target: S_WAIT};
        endcase
    end

    always_comb
    begin
        case (ctrl.cond)
            C_ALWAYS:         cond_hit = 1'b1;
            C_NEVER:          cond_hit = 1'b0;
            C_NO_INPUT:       cond_hit = status.no_input;
            C_CENTRE_INVALID: cond_hit = status.centre_invalid;
            C_I_DONE:         cond_hit = status.i_done;
            C_I_INVALID:      cond_hit = status.i_invalid;
            C_ONE_STEP:       cond_hit = status.one_step;
            C_J_MORE:         cond_hit = status.j_more;
            default:          cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        if (status.stall)
        begin
            step_next = step_reg;
        end
        else if (cond_hit)
        begin
            step_next = ctrl.target;
        end
        else
        begin
            step_next = step_reg + STEP_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    `ASSERT_ALWAYS(a_step_in_program, step_reg <= S_FLUSH, "step counter left the program")
    `ASSERT_NEXT(a_hold_on_stall, status.stall, $stable(step_reg), "step moved while stalled")
    `ASSERT_NEXT(a_flush_returns, step_reg == S_FLUSH && !status.stall, step_reg == S_WAIT, "flush did not return to wait")

endmodule

>>> sv/wcpg_dp.sv
// Datapath: config registers, window, neighbor rings, column math and result staging
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wcpg_dp
    import wcpg_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  in_item_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output out_item_t                out_data,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  ctrl_word_t               ctrl,
    output dp_status_t               status
);

    localparam int DEPTH     = 2 * MAX_WINDOW + 1;
    localparam int NB        = 2 * MAX_WINDOW;
    localparam int WS_BITS   = $clog2(MAX_WINDOW + 1);
    localparam int DIDX_BITS = $clog2(DEPTH);
    localparam int JB        = $clog2(NB);
    localparam int OFF_BITS  = VOCAB_BITS + $clog2(NB);
    localparam int LR_BITS   = VOCAB_BITS + WS_BITS;
    localparam int COL_BITS  = ((OFF_BITS > TOKEN_BITS) ? OFF_BITS : TOKEN_BITS) + 1;

    // Configuration
    logic [WSIZE_BITS-1:0] window_size_reg;
    logic [VOCAB_BITS-1:0] vocab_size_reg;
    logic                  one_step_reg;
    logic [WS_BITS-1:0]    w_eff;
    logic [DIDX_BITS-1:0]  two_w;
    logic [DIDX_BITS-1:0]  centre_idx;

    // Window
    logic [TOKEN_BITS-1:0] win_tok_reg [DEPTH];
    logic                  win_val_reg [DEPTH];
    logic                  accept;

    // Neighbor rings: ri walks the outer loop, rj rotates through the inner loop
    logic [TOKEN_BITS-1:0] ri_tok_reg  [NB];
    logic                  ri_val_reg  [NB];
    logic [TOKEN_BITS-1:0] rj_tok_reg  [NB];
    logic                  rj_val_reg  [NB];
    logic [TOKEN_BITS-1:0] ri_tok_next [NB];
    logic                  ri_val_next [NB];
    logic [TOKEN_BITS-1:0] rj_tok_next [NB];
    logic                  rj_val_next [NB];
    logic [DIDX_BITS-1:0]  load_idx    [NB];
    logic                  load_use    [NB];

    // Loop counters and column values
    logic [DIDX_BITS-1:0]  i_cnt_reg;
    logic [JB-1:0]         j_cnt_reg;
    logic [OFF_BITS-1:0]   off_i_reg;
    logic [OFF_BITS-1:0]   off_j_reg;
    logic [LR_BITS-1:0]    lr_reg;
    logic [TOKEN_BITS-1:0] centre_tok_reg;
    logic [COL_BITS-1:0]   col_i_reg;
    logic                  la_i_reg;
    logic [COL_BITS-1:0]   col_i_next;
    logic [COL_BITS-1:0]   col_j;
    logic [COL_BITS-1:0]   lr_ext;
    logic                  lb;
    logic                  upper;

    // Result staging: one pending result, then the output register
    logic                  emit_req;
    out_item_t             emit_item;
    logic                  flush_req;
    logic                  out_free;
    logic                  stall;
    logic                  advance;
    logic                  pend_valid_reg;
    logic                  pend_valid_next;
    out_item_t             pend_item_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    out_item_t             out_item_reg;
    logic                  out_load;
    logic                  out_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= RST_WINDOW_SIZE;
            vocab_size_reg  <= RST_VOCAB_SIZE;
            one_step_reg    <= RST_ONE_STEP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_SIZE: window_size_reg <= cfg_data[WSIZE_BITS-1:0];
                REG_VOCAB_SIZE:  vocab_size_reg  <= cfg_data[VOCAB_BITS-1:0];
                REG_ONE_STEP:    one_step_reg    <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Clamp the window size into 1..MAX_WINDOW
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            w_eff = WS_BITS'(1);
        end
        else if (window_size_reg > WSIZE_BITS'(MAX_WINDOW))
        begin
            w_eff = WS_BITS'(MAX_WINDOW);
        end
        else
        begin
            w_eff = WS_BITS'(window_size_reg);
        end
    end

    assign two_w      = DIDX_BITS'(w_eff) << 1;
    assign centre_idx = DIDX_BITS'(w_eff);

    assign in_ready = (ctrl.op == OP_ACCEPT);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                win_val_reg[k] <= 1'b0;
            end
        end
        else if (accept)
        begin
            for (int k = DEPTH - 1; k > 0; k--)
            begin
                win_val_reg[k] <= win_val_reg[k - 1];
            end
            win_val_reg[0] <= ~in_data.kind;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = DEPTH - 1; k > 0; k--)
            begin
                win_tok_reg[k] <= win_tok_reg[k - 1];
            end
            win_tok_reg[0] <= in_data.token;
        end
    end

    // Offset slot k maps to window position 2W-k on the left, 2W-k-1 on the right
    always_comb
    begin
        for (int k = 0; k < NB; k++)
        begin
            load_use[k] = DIDX_BITS'(k) < two_w;
            if (!load_use[k])
            begin
                load_idx[k] = '0;
            end
            else if (DIDX_BITS'(k) < centre_idx)
            begin
                load_idx[k] = two_w - DIDX_BITS'(k);
            end
            else
            begin
                load_idx[k] = two_w - DIDX_BITS'(k) - DIDX_BITS'(1);
            end
        end
    end

    always_comb
    begin
        ri_tok_next = ri_tok_reg;
        ri_val_next = ri_val_reg;
        rj_tok_next = rj_tok_reg;
        rj_val_next = rj_val_reg;
        case (ctrl.op)
            OP_LOAD:
            begin
                for (int k = 0; k < NB; k++)
                begin
                    ri_tok_next[k] = win_tok_reg[load_idx[k]];
                    ri_val_next[k] = load_use[k] && win_val_reg[load_idx[k]];
                    rj_tok_next[k] = win_tok_reg[load_idx[k]];
                    rj_val_next[k] = load_use[k] && win_val_reg[load_idx[k]];
                end
            end
            OP_EMIT_CTX, OP_NEXT_I:
            begin
                if (advance)
                begin
                    for (int k = 0; k < NB - 1; k++)
                    begin
                        ri_tok_next[k] = ri_tok_reg[k + 1];
                        ri_val_next[k] = ri_val_reg[k + 1];
                    end
                    ri_val_next[NB - 1] = 1'b0;
                end
            end
            OP_PAIR:
            begin
                // Rotate within the 2W live slots so the ring comes back after the loop
                if (advance)
                begin
                    for (int k = 0; k < NB - 1; k++)
                    begin
                        if (DIDX_BITS'(k) == two_w - DIDX_BITS'(1))
                        begin
                            rj_tok_next[k] = rj_tok_reg[0];
                            rj_val_next[k] = rj_val_reg[0];
                        end
                        else
                        begin
                            rj_tok_next[k] = rj_tok_reg[k + 1];
                            rj_val_next[k] = rj_val_reg[k + 1];
                        end
                    end
                    if (DIDX_BITS'(NB - 1) == two_w - DIDX_BITS'(1))
                    begin
                        rj_tok_next[NB - 1] = rj_tok_reg[0];
                        rj_val_next[NB - 1] = rj_val_reg[0];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ri_tok_reg <= ri_tok_next;
        ri_val_reg <= ri_val_next;
        rj_tok_reg <= rj_tok_next;
        rj_val_reg <= rj_val_next;
    end

    assign col_i_next = COL_BITS'(ri_tok_reg[0]) + COL_BITS'(off_i_reg);
    assign col_j      = COL_BITS'(rj_tok_reg[0]) + COL_BITS'(off_j_reg);
    assign lr_ext     = COL_BITS'(lr_reg);
    assign lb         = col_j < lr_ext;
    // Equal columns fall back to slot order
    assign upper      = (col_i_reg < col_j)
                     || (col_i_reg == col_j && i_cnt_reg <= DIDX_BITS'(j_cnt_reg));

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_LOAD:
            begin
                lr_reg         <= LR_BITS'(w_eff) * LR_BITS'(vocab_size_reg);
                centre_tok_reg <= win_tok_reg[centre_idx];
            end
            OP_START_J:
            begin
                col_i_reg <= col_i_next;
                la_i_reg  <= col_i_next < lr_ext;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        emit_req            = 1'b0;
        emit_item.pair_kind = PK_WORD;
        emit_item.row       = IDX_BITS'(centre_tok_reg);
        emit_item.col       = '0;
        emit_item.last      = 1'b0;
        case (ctrl.op)
            OP_EMIT_WC:
            begin
                emit_req = 1'b1;
            end
            OP_EMIT_CTX:
            begin
                emit_req            = 1'b1;
                emit_item.pair_kind = PK_WORD_CTX;
                emit_item.col       = IDX_BITS'(col_i_reg);
            end
            OP_PAIR:
            begin
                if (la_i_reg && lb && upper)
                begin
                    emit_req            = rj_val_reg[0];
                    emit_item.pair_kind = PK_LEFT_LEFT;
                    emit_item.row       = IDX_BITS'(col_i_reg);
                    emit_item.col       = IDX_BITS'(col_j);
                end
                else if (la_i_reg && !lb)
                begin
                    emit_req            = rj_val_reg[0];
                    emit_item.pair_kind = PK_LEFT_RIGHT;
                    emit_item.row       = IDX_BITS'(col_i_reg);
                    emit_item.col       = IDX_BITS'(col_j - lr_ext);
                end
                else if (!la_i_reg && !lb && upper)
                begin
                    emit_req            = rj_val_reg[0];
                    emit_item.pair_kind = PK_RIGHT_RIGHT;
                    emit_item.row       = IDX_BITS'(col_i_reg - lr_ext);
                    emit_item.col       = IDX_BITS'(col_j - lr_ext);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign flush_req = (ctrl.op == OP_FLUSH);
    assign out_free  = !out_valid_reg || out_ready;
    assign stall     = (emit_req || flush_req) && pend_valid_reg && !out_free;
    assign advance   = !stall;

    // Hold each result back until the next one arrives so the final one can be marked last
    always_comb
    begin
        out_load        = 1'b0;
        out_last        = 1'b0;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        if (advance)
        begin
            if (emit_req)
            begin
                out_load        = pend_valid_reg;
                pend_valid_next = 1'b1;
            end
            else if (flush_req && pend_valid_reg)
            begin
                out_load        = 1'b1;
                out_last        = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            i_cnt_reg      <= '0;
            j_cnt_reg      <= '0;
            off_i_reg      <= '0;
            off_j_reg      <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            case (ctrl.op)
                OP_LOAD:
                begin
                    i_cnt_reg <= '0;
                    off_i_reg <= '0;
                end
                OP_START_J:
                begin
                    j_cnt_reg <= '0;
                    off_j_reg <= '0;
                end
                OP_PAIR:
                begin
                    if (advance)
                    begin
                        j_cnt_reg <= j_cnt_reg + JB'(1);
                        off_j_reg <= off_j_reg + OFF_BITS'(vocab_size_reg);
                    end
                end
                OP_EMIT_CTX, OP_NEXT_I:
                begin
                    if (advance)
                    begin
                        i_cnt_reg <= i_cnt_reg + DIDX_BITS'(1);
                        off_i_reg <= off_i_reg + OFF_BITS'(vocab_size_reg);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit_req)
        begin
            pend_item_reg <= emit_item;
        end
        if (out_load)
        begin
            out_item_reg <= '{pair_kind: pend_item_reg.pair_kind,
                              row:       pend_item_reg.row,
                              col:       pend_item_reg.col,
                              last:      out_last};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    assign status.no_input       = !in_valid;
    assign status.centre_invalid = !win_val_reg[centre_idx];
    assign status.i_done         = (i_cnt_reg == two_w);
    assign status.i_invalid      = !ri_val_reg[0];
    assign status.one_step       = one_step_reg;
    assign status.j_more         = (j_cnt_reg != JB'(two_w - DIDX_BITS'(1)));
    assign status.stall          = stall;

    `ASSERT_IMPLIES(a_pend_empty_at_accept, accept, !pend_valid_reg, "result left pending across items")
    `ASSERT_IMPLIES(a_word_opens_item, ctrl.op == OP_EMIT_WC, !pend_valid_reg, "word count not first of item")
    `ASSERT_ALWAYS(a_i_in_range, i_cnt_reg <= DIDX_BITS'(NB), "outer slot counter overran")

endmodule

>>> verif/window_cooccurrence_pair_generator_top_tb.sv
// Self-checking testbench of the co-occurrence pair generator with its scoreboard
`timescale 1ns / 1ps

module window_cooccurrence_pair_generator_top_tb;
    import wcpg_pkg::*;

    localparam int WIN_DEPTH     = 2 * DEF_MAX_WINDOW + 1;
    localparam int NUM_CTX       = 2 * DEF_MAX_WINDOW;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 45;
    localparam int SETTLE_CYCLES = 32;
    localparam int TAIL_CYCLES   = 128;
    localparam int QUIET_LIMIT   = 5000;
    localparam int REPORT_LIMIT  = 10;

    localparam logic KIND_TOKEN = 1'b0;
    localparam logic KIND_PAD   = 1'b1;

    // Predicts the increments of each accepted item and checks the output against them
    class pair_scoreboard;
        logic [TOKEN_BITS-1:0] win_token [WIN_DEPTH];
        bit                    win_valid [WIN_DEPTH];
        logic [WSIZE_BITS-1:0] reg_wsize;
        logic [VOCAB_BITS-1:0] reg_vocab;
        bit                    reg_one_step;
        out_item_t             pending [$];
        int                    items_in;
        int                    results_ok;
        int                    mismatches;
        int                    unexpected;
        int                    kind_count [5];

        function new();
            for (int k = 0; k < WIN_DEPTH; k++)
            begin
                win_token[k] = '0;
                win_valid[k] = 1'b0;
            end
            for (int k = 0; k < 5; k++)
                kind_count[k] = 0;
            reg_wsize    = RST_WINDOW_SIZE;
            reg_vocab    = RST_VOCAB_SIZE;
            reg_one_step = RST_ONE_STEP;
            items_in     = 0;
            results_ok   = 0;
            mismatches   = 0;
            unexpected   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_WINDOW_SIZE: reg_wsize    = data[WSIZE_BITS-1:0];
                REG_VOCAB_SIZE:  reg_vocab    = data[VOCAB_BITS-1:0];
                REG_ONE_STEP:    reg_one_step = data[0];
                default: ;
            endcase
        endfunction

        function void push_increment(pair_kind_t pk, logic [63:0] row, logic [63:0] col);
            out_item_t r;
            r.pair_kind = pk;
            r.row       = row[IDX_BITS-1:0];
            r.col       = col[IDX_BITS-1:0];
            r.last      = 1'b0;
            if (pending.size() < 1000000)
                pending.insert(pending.size(), r);
        endfunction

        function void note_input(in_item_t item);
            int          w;
            int          slot;
            logic [63:0] left_span;
            logic [63:0] a;
            logic [63:0] b;
            logic [63:0] ctx_col [NUM_CTX];
            bit          ctx_ok [NUM_CTX];
            bit          la;
            bit          lb;
            bit          upper;
            items_in++;
            w = int'(reg_wsize);
            if (w < 1)
                w = 1;
            if (w > DEF_MAX_WINDOW)
                w = DEF_MAX_WINDOW;
            for (int k = WIN_DEPTH - 1; k > 0; k--)
            begin
                win_token[k] = win_token[k-1];
                win_valid[k] = win_valid[k-1];
            end
            win_token[0] = item.token;
            win_valid[0] = (item.kind == KIND_TOKEN);
            // empty center: nothing comes out
            if (!win_valid[w])
                return;
            left_span = 64'(w) * 64'(reg_vocab);
            for (int i = 0; i < 2 * w; i++)
            begin
                slot       = (i < w) ? (2 * w - i) : (2 * w - i - 1);
                ctx_ok[i]  = win_valid[slot];
                ctx_col[i] = 64'(win_token[slot]) + 64'(reg_vocab) * 64'(i);
            end
            push_increment(PK_WORD, 64'(win_token[w]), 64'd0);
            for (int i = 0; i < 2 * w; i++)
            begin
                if (ctx_ok[i])
                begin
                    if (!reg_one_step)
                    begin
                        for (int j = 0; j < 2 * w; j++)
                        begin
                            if (ctx_ok[j])
                            begin
                                a  = ctx_col[i];
                                b  = ctx_col[j];
                                la = a < left_span;
                                lb = b < left_span;
                                // equal columns: lower slot index wins the upper triangle
                                upper = (a < b) || (a == b && i <= j);
                                if (la && lb && upper)
                                    push_increment(PK_LEFT_LEFT, a, b);
                                else if (la && !lb)
                                    push_increment(PK_LEFT_RIGHT, a, b - left_span);
                                else if (!la && !lb && upper)
                                    push_increment(PK_RIGHT_RIGHT, a - left_span,
                                                   b - left_span);
                            end
                        end
                    end
                    push_increment(PK_WORD_CTX, 64'(win_token[w]), ctx_col[i]);
                end
            end
            pending[pending.size()-1].last = 1'b1;
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0)
            begin
                unexpected++;
                if (mismatches + unexpected <= REPORT_LIMIT)
                    $display("%0t: unexpected increment kind %0d row %0d col %0d last %0d",
                             $realtime, got.pair_kind, got.row, got.col, got.last);
                return;
            end
            want = pending.pop_front();
            if (got.pair_kind !== want.pair_kind || got.row !== want.row ||
                got.col !== want.col || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches + unexpected <= REPORT_LIMIT)
                begin
                    $display("%0t: mismatch: expected kind %0d row %0d col %0d last %0d",
                             $realtime, want.pair_kind, want.row, want.col, want.last);
                    $display("    got kind %0d row %0d col %0d last %0d",
                             got.pair_kind, got.row, got.col, got.last);
                end
            end
            else
            begin
                results_ok++;
                kind_count[int'(want.pair_kind)]++;
            end
        endfunction

        function int failures();
            return mismatches + unexpected + pending.size();
        endfunction
    endclass

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    in_item_t                 in_data   = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    out_item_t                out_data;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = REG_WINDOW_SIZE;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    pair_scoreboard sb;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    int             quiet_cycles  = 0;
    int             cur_vocab     = int'(RST_VOCAB_SIZE);
    int             settings_used = 1;

    window_cooccurrence_pair_generator_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Outputs are checked before the input of the same edge is noted: a result
    // leaving at that edge always belongs to an earlier item.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if (in_valid && in_ready)
                sb.note_input(in_data);
            if ((out_valid && out_ready) || (in_valid && in_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: timeout, no transfer for %0d cycles", $realtime, QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Present one item, idling at random first; valid stays high after the transfer
    task automatic send_item(logic kind_bit, logic [TOKEN_BITS-1:0] tok);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{kind: kind_bit, token: tok};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Hold the input until every predicted increment has come out
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(int ws, int vocab, bit one_step);
        wait_for_results();
        // an item with an empty center may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_WINDOW_SIZE, CFG_DATA_BITS'(ws));
        write_reg(REG_VOCAB_SIZE, CFG_DATA_BITS'(vocab));
        write_reg(REG_ONE_STEP, CFG_DATA_BITS'(one_step));
        cfg_we    <= 1'b0;
        cur_vocab = vocab;
        settings_used++;
    endtask

    function automatic logic [TOKEN_BITS-1:0] pick_token();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = 32'd0;
            1:       v = 32'hFFFFF;
            2:       v = $urandom_range(0, 15);
            3:       v = $urandom;
            4:       v = cur_vocab + $urandom_range(0, 3) - 2;
            default: v = (cur_vocab > 0) ? ($urandom % cur_vocab) : $urandom;
        endcase
        return v[TOKEN_BITS-1:0];
    endfunction

    initial
    begin : stimulus
        int phase_ws    [NUM_PHASES] = '{3, 0, 7, 4, 2, 1, 5, 6};
        int phase_vocab [NUM_PHASES] = '{1000, 1048576, 2097151, 16, 0, 1, 1, 1};
        bit phase_one   [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
        int sent;
        int n_tok;
        int n_pad;
        sb = new();
        send_idle_pct = 12;
        recv_idle_pct = 68;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: empty window, extreme tokens, pads with junk token bits
        send_item(KIND_PAD, 20'h00000);
        send_item(KIND_TOKEN, 20'h00000);
        send_item(KIND_TOKEN, 20'hFFFFF);
        send_item(KIND_TOKEN, 20'h00001);
        send_item(KIND_TOKEN, 20'h80000);
        send_item(KIND_TOKEN, 20'hFFFFF);
        send_item(KIND_PAD, 20'hFFFFF);
        send_item(KIND_PAD, 20'h00000);
        send_item(KIND_TOKEN, 20'h55555);

        // widest window in two-step mode: a full window gives the longest burst
        set_config(4, 1048576, 1'b0);
        send_item(KIND_TOKEN, 20'hFFFFF);
        send_item(KIND_TOKEN, 20'h00000);
        send_item(KIND_TOKEN, 20'hAAAAA);
        send_item(KIND_TOKEN, 20'h00003);
        send_item(KIND_TOKEN, 20'h00007);
        send_item(KIND_TOKEN, 20'h00001);
        send_item(KIND_TOKEN, 20'h55555);
        send_item(KIND_TOKEN, 20'hFFFFF);
        send_item(KIND_TOKEN, 20'h00002);
        send_item(KIND_PAD, 20'h12345);

        // tokens past the vocabulary: equal columns from two slots, left-right split
        set_config(1, 1, 1'b0);
        send_item(KIND_TOKEN, 20'h00005);
        send_item(KIND_TOKEN, 20'h00007);
        send_item(KIND_TOKEN, 20'h00004);
        send_item(KIND_TOKEN, 20'h00000);
        send_item(KIND_TOKEN, 20'h00009);
        send_item(KIND_TOKEN, 20'h00000);

        phase_vocab[5] = $urandom_range(1, 1048576);
        phase_vocab[6] = $urandom_range(2, 300);
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_config(phase_ws[p], phase_vocab[p], phase_one[p]);
            if (p < 3)
            begin
                send_idle_pct = 12;
                recv_idle_pct = 68;
            end
            else if (p < 6)
            begin
                send_idle_pct = 68;
                recv_idle_pct = 12;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 80)
                begin
                    // sentence of real tokens, then the pads that close it
                    n_tok = $urandom_range(1, 10);
                    n_pad = $urandom_range(0, 5);
                    for (int k = 0; k < n_tok; k++)
                        send_item(KIND_TOKEN, pick_token());
                    for (int k = 0; k < n_pad; k++)
                        send_item(KIND_PAD, TOKEN_BITS'($urandom));
                    sent += n_tok + n_pad;
                end
                else
                begin
                    send_item(1'($urandom_range(0, 1)), TOKEN_BITS'($urandom));
                    sent++;
                end
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d input items and %0d checked increments over %0d settings",
                 sb.items_in, sb.results_ok, settings_used);
        $display(
            "Kinds: word %0d, ctx %0d, LL %0d, LR %0d, RR %0d; %0d bad, %0d unexpected",
            sb.kind_count[0], sb.kind_count[1], sb.kind_count[2], sb.kind_count[3],
            sb.kind_count[4], sb.mismatches, sb.unexpected);
        if (sb.failures() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> window_cooccurrence_pair_generator_top.f
+incdir+sv
sv/wcpg_pkg.sv
sv/wcpg_seq.sv
sv/wcpg_dp.sv
sv/window_cooccurrence_pair_generator_top.sv
verif/window_cooccurrence_pair_generator_top_tb.sv
